// ----- rtl/core/bdbm_pkg.sv -----
// ----------------------------------------------------------------------------
// bdbm_pkg
// Shared types and codes for the bus decoder with bank mapper.
// ----------------------------------------------------------------------------
package bdbm_pkg;

  // access modes
  localparam logic [2:0] MODE_MEM_RD = 3'd0;
  localparam logic [2:0] MODE_MEM_WR = 3'd1;
  localparam logic [2:0] MODE_IO_RD  = 3'd2;
  localparam logic [2:0] MODE_IO_WR  = 3'd3;
  localparam logic [2:0] MODE_INTA   = 3'd4;

  // targets
  localparam logic [3:0] TGT_RAM   = 4'd0;
  localparam logic [3:0] TGT_ROM   = 4'd1;
  localparam logic [3:0] TGT_SCC   = 4'd2;
  localparam logic [3:0] TGT_PSG   = 4'd3;
  localparam logic [3:0] TGT_MUSIC = 4'd4;
  localparam logic [3:0] TGT_AUDIO = 4'd5;
  localparam logic [3:0] TGT_SN    = 4'd6;
  localparam logic [3:0] TGT_FM    = 4'd7;
  localparam logic [3:0] TGT_NONE  = 4'd8;

  // bank modes
  localparam logic [1:0] BM_OFF = 2'd0;
  localparam logic [1:0] BM_16K = 2'd1;
  localparam logic [1:0] BM_8K  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_BANK_MODE    = 3'd0;
  localparam logic [2:0] CFG_BANK_OFFSET  = 3'd1;
  localparam logic [2:0] CFG_BANK_COUNT   = 3'd2;
  localparam logic [2:0] CFG_RAM_MODE     = 3'd3;
  localparam logic [2:0] CFG_SMS_MODE     = 3'd4;
  localparam logic [2:0] CFG_PROTECT_LOW  = 3'd5;
  localparam logic [2:0] CFG_DEVICES      = 3'd6;
  localparam int unsigned CFG_DATA_W      = 8;

  // mapper addresses and ports
  localparam logic [15:0] ADDR_MAP_LOW  = 16'h9000;
  localparam logic [15:0] ADDR_MAP_HIGH = 16'hB000;
  localparam logic [7:0]  PORT_PSG_RD   = 8'hA2;
  localparam logic [7:0]  PORT_PSG_WR   = 8'hA0;
  localparam logic [7:0]  PORT_PSG_IO   = 8'hAB;
  localparam logic [7:0]  PORT_MUSIC    = 8'h7C;
  localparam logic [7:0]  PORT_AUDIO    = 8'hC0;
  localparam logic [7:0]  PORT_SN       = 8'h7E;
  localparam logic [7:0]  PORT_SN_ALT   = 8'h06;
  localparam logic [7:0]  PORT_FM       = 8'hF0;
  localparam logic [7:0]  PORT_MAP16K   = 8'hFE;

  // answers
  localparam logic [7:0] ANS_UNCLAIMED = 8'hFF;
  localparam logic [7:0] ANS_INTA      = 8'h38;

  // pages
  localparam logic [2:0] PAGE_2      = 3'd2;
  localparam logic [2:0] PAGE_3      = 3'd3;
  localparam logic [2:0] PAGE_BANK_L = 3'd4;
  localparam logic [2:0] PAGE_BANK_H = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  target;
    logic        is_write;
    logic [20:0] location;
    logic [7:0]  out_data;
    logic        answered_here;
  } out_item_t;

  typedef struct packed {
    logic [1:0] bank_mode;
    logic [7:0] bank_offset;
    logic [6:0] bank_count;
    logic       ram_mode;
    logic       sms_mode;
    logic       protect_low_pages;
    logic [2:0] devices_present;
  } cfg_t;

  typedef struct packed {
    logic       low_mapped;
    logic [6:0] low_bank;
    logic       high_mapped;
    logic [6:0] high_bank;
    logic       scc_enable;
  } map_t;

  typedef struct packed {
    logic       wr_low;
    logic       wr_high;
    logic       ok;
    logic [6:0] bank;
    logic       wr_scc;
    logic       scc_val;
  } upd_t;

endpackage

// ----- rtl/core/bus_decoder_with_bank_mapper.sv -----
// ----------------------------------------------------------------------------
// bus_decoder_with_bank_mapper
// Decodes CPU bus accesses and tracks the 8K/16K ROM bank mapping.
//
//   channel  | ports                          | beat
//   ---------+--------------------------------+--------------------------
//   input    | in_valid, in_stall, in_payload | one bus access
//   result   | out_valid, out_stall, out_payload | one routed access
//   config   | cfg_we, cfg_index, cfg_data    | one register write
//
// One beat per cycle while the result side does not stall; a taken beat
// passes the input register, then decode into the result register.
// Mapper updates land as the beat enters the result register, so the next
// beat already decodes against them.
// Reset is synchronous and clears the mapping; the SCC flag comes up set.
// A stalled result holds the result register; a full input register is held too and stalls the input side.
// ----------------------------------------------------------------------------
module bus_decoder_with_bank_mapper import bdbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_payload,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_payload,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic      in_valid_r, in_valid_nxt;
  in_item_t  in_item_r, in_item_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;
  logic      adv;
  logic      apply;
  cfg_t      cfg;
  map_t      map;
  out_item_t res;
  upd_t      upd;

  bdbm_decode u_decode (
    .item (in_item_r),
    .cfg  (cfg),
    .map  (map),
    .res  (res),
    .upd  (upd)
  );

  bdbm_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .apply     (apply),
    .upd       (upd),
    .cfg       (cfg),
    .map       (map)
  );

  assign adv      = !out_valid_r || !out_stall;
  assign apply    = adv && in_valid_r;
  assign in_stall = in_valid_r && !adv;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_item_nxt   = in_item_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (!in_stall) begin
      in_valid_nxt = in_valid;
      in_item_nxt  = in_payload;
    end
    if (adv) begin
      out_valid_nxt = in_valid_r;
      out_item_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_item_r  <= in_item_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_item_r;

endmodule

// ----- rtl/core/bdbm_decode.sv -----
// ----------------------------------------------------------------------------
// bdbm_decode
// Routes one bus access and computes the mapper update it causes.
// ----------------------------------------------------------------------------
module bdbm_decode import bdbm_pkg::*; (
  input  in_item_t  item,
  input  cfg_t      cfg,
  input  map_t      map,
  output out_item_t res,
  output upd_t      upd
);

  logic [2:0]  page;
  logic [7:0]  port;
  logic [8:0]  diff;
  logic        ok;
  logic        banked;
  logic        plain;
  logic        mapped;
  logic [6:0]  bank;
  logic        map16k;

  always_comb begin
    page   = item.address[15:13];
    port   = item.address[7:0];
    diff   = {1'b0, item.data} - {1'b0, cfg.bank_offset};
    ok     = !diff[8] && (diff[7:0] < {1'b0, cfg.bank_count});
    banked = (page == PAGE_BANK_L) || (page == PAGE_BANK_H);
    plain  = !banked && !(cfg.protect_low_pages && ((page == PAGE_2) || (page == PAGE_3)));
    mapped = (page == PAGE_BANK_H) ? map.high_mapped : map.low_mapped;
    bank   = (page == PAGE_BANK_H) ? map.high_bank : map.low_bank;
    map16k = (port == PORT_MAP16K) && (cfg.bank_mode == BM_16K);

    res = '0;
    res.target = TGT_NONE;
    upd = '0;
    upd.ok = ok;
    upd.bank = ok ? diff[6:0] : 7'd0;
    upd.scc_val = ok || !cfg.ram_mode;

    case (item.mode)
      MODE_MEM_RD: begin
        if (banked && mapped) begin
          res.target = TGT_ROM;
          if (cfg.bank_mode == BM_16K) begin
            res.location = {bank, item.address[13:0]};
          end else begin
            res.location = {1'b0, bank, item.address[12:0]};
          end
        end else begin
          res.target   = TGT_RAM;
          res.location = {5'd0, item.address};
        end
      end
      MODE_MEM_WR: begin
        if (plain) begin
          res.target   = TGT_RAM;
          res.is_write = 1'b1;
          res.location = {5'd0, item.address};
          res.out_data = item.data;
        end else if (cfg.bank_mode == BM_8K) begin
          if (item.address == ADDR_MAP_LOW) begin
            upd.wr_low = 1'b1;
          end else if (item.address == ADDR_MAP_HIGH) begin
            upd.wr_high = 1'b1;
          end else if (map.scc_enable) begin
            res.target   = TGT_SCC;
            res.is_write = 1'b1;
            res.location = {5'd0, item.address};
            res.out_data = item.data;
          end
        end else if (map.scc_enable) begin
          res.target   = TGT_SCC;
          res.is_write = 1'b1;
          res.location = {5'd0, item.address};
          res.out_data = item.data;
        end else if (cfg.ram_mode) begin
          res.target   = TGT_RAM;
          res.is_write = 1'b1;
          res.location = {5'd0, item.address};
          res.out_data = item.data;
        end
      end
      MODE_IO_RD: begin
        if (!cfg.sms_mode && (port == PORT_PSG_RD)) begin
          res.target = TGT_PSG;
        end else if (!cfg.sms_mode && cfg.devices_present[2] &&
                     (port[7:1] == PORT_AUDIO[7:1])) begin
          res.target   = TGT_AUDIO;
          res.location = {20'd0, port[0]};
        end else begin
          res.out_data      = ANS_UNCLAIMED;
          res.answered_here = 1'b1;
        end
      end
      MODE_IO_WR: begin
        if (cfg.sms_mode) begin
          if (port[7:1] == PORT_SN[7:1]) begin
            res.target   = TGT_SN;
            res.is_write = 1'b1;
            res.out_data = item.data;
          end else if (port == PORT_SN_ALT) begin
            res.target   = TGT_SN;
            res.is_write = 1'b1;
            res.location = 21'd1;
            res.out_data = item.data;
          end else if (cfg.devices_present[0] && (port[7:1] == PORT_FM[7:1])) begin
            res.target   = TGT_FM;
            res.is_write = 1'b1;
            res.location = {20'd0, port[0]};
            res.out_data = item.data;
          end else if (map16k) begin
            upd.wr_low  = 1'b1;
            upd.wr_high = 1'b1;
          end
        end else begin
          if (port[7:1] == PORT_PSG_WR[7:1]) begin
            res.target   = TGT_PSG;
            res.is_write = 1'b1;
            res.location = {20'd0, port[0]};
            res.out_data = item.data;
          end else if (port == PORT_PSG_IO) begin
            res.target   = TGT_PSG;
            res.is_write = 1'b1;
            res.location = 21'd2;
            res.out_data = {7'd0, item.data[0]};
          end else if (cfg.devices_present[1] && (port[7:1] == PORT_MUSIC[7:1])) begin
            res.target   = TGT_MUSIC;
            res.is_write = 1'b1;
            res.location = {20'd0, port[0]};
            res.out_data = item.data;
          end else if (cfg.devices_present[2] && (port[7:1] == PORT_AUDIO[7:1])) begin
            res.target   = TGT_AUDIO;
            res.is_write = 1'b1;
            res.location = {20'd0, port[0]};
            res.out_data = item.data;
          end else if (map16k) begin
            upd.wr_low  = 1'b1;
            upd.wr_high = 1'b1;
            upd.wr_scc  = 1'b1;
          end
        end
      end
      MODE_INTA: begin
        res.out_data      = ANS_INTA;
        res.answered_here = 1'b1;
      end
      default: begin
        res.target = TGT_NONE;
      end
    endcase
  end

endmodule

// ----- rtl/core/bdbm_state.sv -----
// ----------------------------------------------------------------------------
// bdbm_state
// Configuration registers, page mapping and SCC enable flag.
// ----------------------------------------------------------------------------
module bdbm_state import bdbm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  apply,
  input  upd_t                  upd,
  output cfg_t                  cfg,
  output map_t                  map
);

  cfg_t cfg_r, cfg_nxt;
  map_t map_r, map_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    map_nxt = map_r;
    if (apply) begin
      if (upd.wr_low) begin
        map_nxt.low_mapped = upd.ok;
        map_nxt.low_bank   = upd.bank;
      end
      if (upd.wr_high) begin
        map_nxt.high_mapped = upd.ok;
        map_nxt.high_bank   = upd.bank;
      end
      if (upd.wr_scc) begin
        map_nxt.scc_enable = upd.scc_val;
      end
    end
    if (cfg_we) begin
      case (cfg_index)
        CFG_BANK_MODE:   cfg_nxt.bank_mode   = cfg_data[1:0];
        CFG_BANK_OFFSET: cfg_nxt.bank_offset = cfg_data[7:0];
        CFG_BANK_COUNT:  cfg_nxt.bank_count  = cfg_data[6:0];
        CFG_RAM_MODE: begin
          cfg_nxt.ram_mode   = cfg_data[0];
          map_nxt.scc_enable = !cfg_r.sms_mode && !cfg_data[0];
        end
        CFG_SMS_MODE: begin
          cfg_nxt.sms_mode   = cfg_data[0];
          map_nxt.scc_enable = !cfg_data[0] && !cfg_r.ram_mode;
        end
        CFG_PROTECT_LOW: cfg_nxt.protect_low_pages = cfg_data[0];
        CFG_DEVICES:     cfg_nxt.devices_present   = cfg_data[2:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
      map_r <= '{scc_enable: 1'b1, default: '0};
    end else begin
      cfg_r <= cfg_nxt;
      map_r <= map_nxt;
    end
  end

  assign cfg = cfg_r;
  assign map = map_r;

endmodule
